FILE: rtl/core/pmq_pkg.sv
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared sizes, codes and helpers for the partitioned multi-queue.
// ----------------------------------------------------------------------------
package pmq_pkg;

    localparam int TOTAL_WORDS = 128;
    localparam int QUEUE_COUNT = 4;
    localparam int DATA_WIDTH  = 32;

    localparam int PART_WORDS = TOTAL_WORDS / QUEUE_COUNT;
    localparam int ADDR_W     = $clog2(TOTAL_WORDS);
    localparam int CNT_W      = $clog2(TOTAL_WORDS + 1);
    localparam int QID_W      = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

    localparam int QUEUE_ID_W = 3;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_QUEUE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic start_read;
        logic load_read;
    } cmd_t;

    typedef struct packed {
        logic needs_read;
        logic out_free;
    } stat_t;

    function automatic logic [ADDR_W-1:0] part_base(input logic [QID_W-1:0] q);
        logic [31:0] b;
        b = 32'(q) * 32'(PART_WORDS);
        return b[ADDR_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] part_size(input logic [QID_W-1:0] q);
        logic [31:0] s;
        if (32'(q) == 32'(QUEUE_COUNT - 1)) begin
            s = 32'(TOTAL_WORDS) - 32'(q) * 32'(PART_WORDS);
        end else begin
            s = 32'(PART_WORDS);
        end
        return s[CNT_W-1:0];
    endfunction

    function automatic logic [DATA_WIDTH-1:0] fit_store(input logic [WORD_W-1:0] w);
        logic [63:0] t;
        t = 64'(w);
        return t[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] fit_out(input logic [DATA_WIDTH-1:0] w);
        logic [63:0] t;
        t = 64'(w);
        return t[WORD_W-1:0];
    endfunction

endpackage

FILE: rtl/core/pmq_ctrl.sv
// ----------------------------------------------------------------------------
// pmq_ctrl
// Operation sequencer: accept, check, optional store read, hand off result.
// ----------------------------------------------------------------------------
module pmq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  pmq_pkg::stat_t st,
    output pmq_pkg::cmd_t  cmd
);
    import pmq_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (st.needs_read) state_next = ST_READ;
                else if (st.out_free) state_next = ST_IDLE;
            end
            ST_READ: begin
                if (st.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_CHECK: begin
                cmd.start_read = st.needs_read;
                cmd.exec       = !st.needs_read && st.out_free;
            end
            ST_READ: begin
                cmd.load_read = st.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/pmq_datapath.sv
// ----------------------------------------------------------------------------
// pmq_datapath
// Operation register, queue counters, shared word store and result register.
// ----------------------------------------------------------------------------
module pmq_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_op,
    input  logic [pmq_pkg::QUEUE_ID_W-1:0]  in_queue_id,
    input  logic [pmq_pkg::WORD_W-1:0]      in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pmq_pkg::WORD_W-1:0]      out_data,
    output logic [pmq_pkg::STATUS_W-1:0]    out_status,
    input  pmq_pkg::cmd_t                   cmd,
    output pmq_pkg::stat_t                  st
);
    import pmq_pkg::*;

    logic                  op_reg;
    logic [QUEUE_ID_W-1:0] qid_reg;
    logic [WORD_W-1:0]     data_reg;

    logic [CNT_W-1:0] wc_reg [QUEUE_COUNT];
    logic [CNT_W-1:0] rc_reg [QUEUE_COUNT];

    logic [DATA_WIDTH-1:0] mem [TOTAL_WORDS];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                out_valid_reg;
    logic [WORD_W-1:0]   out_data_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [QID_W-1:0]  qi;
    logic              qid_bad;
    logic [CNT_W-1:0]  wc_cur, rc_cur, size_cur;
    logic              full, empty;
    logic [ADDR_W-1:0] addr;
    logic              mem_we;
    logic [WORD_W-1:0] fail_word;
    logic [WORD_W-1:0] exec_data;
    logic [STATUS_W-1:0] exec_status;

    assign qi        = qid_reg[QID_W-1:0];
    assign qid_bad   = 32'(qid_reg) >= 32'(QUEUE_COUNT);
    assign wc_cur    = wc_reg[qi];
    assign rc_cur    = rc_reg[qi];
    assign size_cur  = part_size(qi);
    assign full      = wc_cur >= size_cur;
    assign empty     = rc_cur >= wc_cur;
    assign addr      = part_base(qi) + ((op_reg == OP_DEQ) ? rc_cur[ADDR_W-1:0]
                                                           : wc_cur[ADDR_W-1:0]);
    assign fail_word = fit_out({DATA_WIDTH{1'b1}});
    assign mem_we    = cmd.exec && !qid_bad && (op_reg == OP_ENQ) && !full;

    assign st.needs_read = !qid_bad && (op_reg == OP_DEQ) && !empty;
    assign st.out_free   = !out_valid_reg || out_ready;

    always_comb begin
        priority if (qid_bad) begin
            exec_status = STAT_BAD_QUEUE;
            exec_data   = (op_reg == OP_DEQ) ? fail_word : '0;
        end else if (op_reg == OP_ENQ) begin
            exec_status = full ? STAT_OVERFLOW : STAT_OK;
            exec_data   = '0;
        end else begin
            exec_status = STAT_UNDERFLOW;
            exec_data   = fail_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg   <= OP_ENQ;
            qid_reg  <= '0;
            data_reg <= '0;
        end else if (cmd.capture) begin
            op_reg   <= in_op;
            qid_reg  <= in_queue_id;
            data_reg <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                wc_reg[i] <= '0;
                rc_reg[i] <= '0;
            end
        end else begin
            if (mem_we) wc_reg[qi] <= wc_cur + CNT_W'(1);
            if (cmd.start_read) rc_reg[qi] <= rc_cur + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[addr] <= fit_store(data_reg);
        if (cmd.start_read) rd_data_reg <= mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.exec || cmd.load_read) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_data_reg   <= exec_data;
            out_status_reg <= exec_status;
        end else if (cmd.load_read) begin
            out_data_reg   <= fit_out(rd_data_reg);
            out_status_reg <= STAT_OK;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec || cmd.load_read) |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending beat");

    a_read_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_read |-> (!qid_bad && !empty && op_reg == OP_DEQ))
        else $error("store read on a failing dequeue");

    a_wc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !qid_bad |-> (wc_cur <= size_cur))
        else $error("write count beyond partition");

    a_rc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !qid_bad |-> (rc_cur <= wc_cur))
        else $error("read count beyond write count");
`endif

endmodule

FILE: rtl/core/partitioned_multi_queue.sv
// ----------------------------------------------------------------------------
// partitioned_multi_queue
// Several linear queues sharing one partitioned word store.
// ----------------------------------------------------------------------------
//  channel | dir | tdata          | tuser
//  s_      | in  | data_in[31:0]  | op[0], queue_id[3:1]
//  m_      | out | data_out[31:0] | status[1:0]
//
//  Enqueue and failing operations load the result register from the check
//  state; a successful dequeue adds a read state for the registered store
//  read port before the result is loaded.
//  One operation is in flight at a time; the result register frees the
//  input side while a beat waits on m_tready.
//  aresetn (synchronous) clears all queue counters; store contents persist.
//  A stalled result holds the sequencer only when the next result is ready.
// ----------------------------------------------------------------------------
module partitioned_multi_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_in[31:0]
    input  logic [3:0]  s_tuser,   // op[0], queue_id[3:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data_out[31:0]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import pmq_pkg::*;

    cmd_t  cmd;
    stat_t st;

    pmq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pmq_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_op       (s_tuser[0]),
        .in_queue_id (s_tuser[3:1]),
        .in_data     (s_tdata),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_status  (m_tuser),
        .cmd         (cmd),
        .st          (st)
    );

endmodule

FILE: tb/partitioned_multi_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// partitioned_multi_queue_tb
// Streams enqueue and dequeue beats into the partitioned multi-queue and
// checks every result beat against a local model of the partitioned store.
// A short directed sequence covers extreme words, empty and bad queues and
// the last partition. Random traffic follows; its length and mix fill and
// overflow every partition. Both sides stall at random, except
// during one stretch that has no stalls.
// ----------------------------------------------------------------------------
module partitioned_multi_queue_tb;
    import pmq_pkg::*;

    typedef struct packed {
        logic                  op;
        logic [QUEUE_ID_W-1:0] qid;
        logic [WORD_W-1:0]     data;
    } queue_op_t;

    typedef struct packed {
        logic [WORD_W-1:0]   data;
        logic [STATUS_W-1:0] status;
    } queue_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // data_in[31:0]
    logic [3:0]  s_tuser  = '0;   // op[0], queue_id[3:1]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // data_out[31:0]
    logic [1:0]  m_tuser;         // status[1:0]

    queue_op_t     pending_ops[$];
    queue_result_t expected_results[$];

    logic [DATA_WIDTH-1:0] word_mem [TOTAL_WORDS];
    int                    wr_cnt   [QUEUE_COUNT];
    int                    rd_cnt   [QUEUE_COUNT];

    int  total_ops   = 0;
    int  sent_ops    = 0;
    int  taken_ops   = 0;
    int  cycle_cnt   = 0;
    bit  failed      = 1'b0;

    partitioned_multi_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic bit stall_now();
        bit quiet;
        quiet = (cycle_cnt >= 2000) && (cycle_cnt < 2600);
        return !quiet && ($urandom_range(99) < 35);
    endfunction

    function automatic void push_op(input logic op, input int qid, input logic [31:0] data);
        queue_op_t item;
        item.op   = op;
        item.qid  = QUEUE_ID_W'(qid);
        item.data = data;
        pending_ops.push_back(item);
        total_ops++;
    endfunction

    function automatic void queue_op_apply(input logic op, input logic [QUEUE_ID_W-1:0] qid,
                                           input logic [WORD_W-1:0] din);
        queue_result_t         res;
        logic [DATA_WIDTH-1:0] all_ones;
        int                    q;
        int                    base;
        int                    size;
        all_ones   = '1;
        res.data   = '0;
        res.status = STAT_OK;
        q          = int'(qid);
        if (q >= QUEUE_COUNT) begin
            res.status = STAT_BAD_QUEUE;
            if (op == OP_DEQ) res.data = WORD_W'(all_ones);
        end else begin
            base = q * PART_WORDS;
            size = (q == QUEUE_COUNT - 1) ? TOTAL_WORDS - base : PART_WORDS;
            if (op == OP_ENQ) begin
                if (wr_cnt[q] >= size) begin
                    res.status = STAT_OVERFLOW;
                end else begin
                    word_mem[base + wr_cnt[q]] = DATA_WIDTH'(din);
                    wr_cnt[q]++;
                end
            end else begin
                if (rd_cnt[q] >= wr_cnt[q]) begin
                    res.status = STAT_UNDERFLOW;
                    res.data   = WORD_W'(all_ones);
                end else begin
                    res.data = WORD_W'(word_mem[base + rd_cnt[q]]);
                    rd_cnt[q]++;
                end
            end
        end
        expected_results.push_back(res);
    endfunction

    // driver: hold the beat until taken, then advance or idle
    always @(negedge aclk) begin
        queue_op_t item;
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn) begin
            m_tready <= !stall_now();
            if (!(s_tvalid && taken_ops < sent_ops)) begin
                if (pending_ops.size() > 0 && !stall_now()) begin
                    item = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.data;
                    s_tuser  <= {item.qid, item.op};
                    sent_ops <= sent_ops + 1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                queue_op_apply(s_tuser[0], s_tuser[3:1], s_tdata);
                taken_ops = taken_ops + 1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat: data_out %h status %0d", m_tdata, m_tuser);
                    failed = 1'b1;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.data) begin
                        $error("data_out expected %h actual %h", want.data, m_tdata);
                        failed = 1'b1;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_tuser);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    initial begin
        int  qid;
        bit  op;
        for (int q = 0; q < QUEUE_COUNT; q++) begin
            wr_cnt[q] = 0;
            rd_cnt[q] = 0;
        end

        push_op(OP_ENQ, 0, 32'h8000_0000);
        push_op(OP_ENQ, 0, 32'h7fff_ffff);
        push_op(OP_ENQ, 0, 32'h0000_0000);
        push_op(OP_ENQ, 0, 32'hffff_ffff);
        for (int i = 0; i < 5; i++) push_op(OP_DEQ, 0, 32'h0);
        push_op(OP_DEQ, 1, 32'hffff_ffff);
        push_op(OP_ENQ, QUEUE_COUNT - 1, 32'ha5a5_a5a5);
        push_op(OP_DEQ, QUEUE_COUNT - 1, 32'h0);
        push_op(OP_DEQ, QUEUE_COUNT - 1, 32'h0);
        push_op(OP_ENQ, 1, 32'h5a5a_5a5a);
        push_op(OP_ENQ, 2, 32'h1234_5678);
        push_op(OP_DEQ, 2, 32'h0);
        push_op(OP_DEQ, 1, 32'h0);
        for (int q = 4; q < 8; q++) begin
            push_op(OP_ENQ, q, 32'hdead_beef);
            push_op(OP_DEQ, q, 32'hffff_ffff);
        end

        for (int i = 0; i < 1130; i++) begin
            if (QUEUE_COUNT < 8 && $urandom_range(9) == 0) qid = $urandom_range(7, QUEUE_COUNT);
            else qid = $urandom_range(QUEUE_COUNT - 1);
            op = ($urandom_range(99) < 30) ? OP_ENQ : OP_DEQ;
            push_op(op, qid, $urandom);
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (taken_ops < total_ops) @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (expected_results.size() > 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
